/* rtl/modbus_ascii_frame_receiver_core_assert.svh */
// Assertion macros shared by the frame receiver modules.
`ifndef MODBUS_ASCII_FRAME_RECEIVER_CORE_ASSERT_SVH
`define MODBUS_ASCII_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MBAFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("frame receiver assertion failed");
`define MBAFR_ASSERT_NEVER(lbl, cond) \
  `MBAFR_ASSERT(lbl, !(cond))
`else
`define MBAFR_ASSERT(lbl, prop)
`define MBAFR_ASSERT_NEVER(lbl, cond)
`endif

`endif

/* rtl/mbafr_pkg.sv */
// Shared constants, types and state codes of the frame receiver.
package mbafr_pkg;

  localparam int unsigned MaxFrameBytes = 64;
  localparam int unsigned AddrW         = $clog2(MaxFrameBytes);
  localparam int unsigned RamDepth      = 2 ** (AddrW + 1);
  localparam int unsigned CharW         = $clog2(2 * MaxFrameBytes + 4);
  localparam int unsigned IdxW          = CharW - 1;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned HdrBytes      = 6;
  localparam int unsigned HdrIdxW       = $clog2(HdrBytes);

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  localparam logic [7:0] FnReadCoils  = 8'd1;
  localparam logic [7:0] FnReadRegs   = 8'd3;
  localparam logic [7:0] FnWriteCoil  = 8'd5;
  localparam logic [7:0] FnWriteCoils = 8'd15;

  localparam int unsigned FixedFrameChars   = 17;
  localparam int unsigned MinCoilFrameChars = 21;
  localparam int unsigned FirstDataByte     = 7;

  localparam logic [7:0] OwnAddrReset = 8'd1;

  localparam logic KindHeader = 1'b0;
  localparam logic KindData   = 1'b1;

  // One accepted frame, handed from the character side to the result side.
  typedef struct packed {
    logic             bank;
    logic [7:0]       fn;
    logic             bcast;
    logic [15:0]      start;
    logic [15:0]      count;
    logic [AddrW-1:0] ndata;
  } job_t;

  typedef enum logic [2:0] {
    BackIdle = 3'b001,
    BackRead = 3'b010,
    BackLoad = 3'b100
  } back_state_e;

endpackage

/* rtl/mbafr_char_if.sv */
// Character channel: one received character per beat.
interface mbafr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

/* rtl/mbafr_result_if.sv */
// Result channel: one frame header or coil data byte per beat.
interface mbafr_result_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  function_code;
  logic        is_broadcast;
  logic [15:0] start_address;
  logic [15:0] count_or_value;
  logic [7:0]  data_byte;
  logic        last_of_frame;

  modport source (
    output valid, output item_kind, output function_code, output is_broadcast,
    output start_address, output count_or_value, output data_byte,
    output last_of_frame, input ready
  );
  modport sink (
    input valid, input item_kind, input function_code, input is_broadcast,
    input start_address, input count_or_value, input data_byte,
    input last_of_frame, output ready
  );
endinterface

/* rtl/modbus_ascii_frame_receiver_core.sv */
// Top level of the Modbus ASCII frame receiver core.
//
// This core takes one received character per beat, finds Modbus ASCII frames
// that start with a colon, decodes the hex pairs into bytes, keeps a running
// LRC and checks the station address, the function code (1, 3, 5 or 15), the
// CR LF trailer and the LRC. Each accepted frame gives one header beat, and a
// function 15 frame is followed by one beat per coil data byte; the last beat
// of a frame has last_of_frame set. Rejected frames give no beats, and a colon
// always restarts frame parsing. The character side accepts one character
// every cycle unless stalled. Decoded bytes go into a frame store with two
// banks, so one frame's results can drain while the next frame is received;
// the character channel stalls only while two accepted frames still wait for
// their last result beats to be loaded. On the result side each coil data byte
// is read from the frame store, whose read data is registered, before its beat.
// A frame that would need more than the store size of 64 bytes is dropped.
// The station address register resets to 1 and should be written only while
// the core is idle. The frame store needs no clearing after reset.
module modbus_ascii_frame_receiver_core import mbafr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  mbafr_char_if.sink     rx_i,
  mbafr_result_if.source res_o
);

  job_t           push_job;
  job_t           head_job;
  logic           push;
  logic           pop;
  logic           q_valid;
  logic           q_full;
  logic           ram_we;
  logic [AddrW:0] ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [AddrW:0] ram_raddr;
  logic [7:0]     ram_rdata;

  // Character side: parsing and checking of incoming frames.
  mbafr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  // Accepted frames wait here; each entry owns one bank of the frame store
  // until its last result beat has been loaded.
  mbafr_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  // Frame store: the bank bit is the top address bit.
  mbafr_ram #(
    .Width (8),
    .Depth (RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result side: header and coil data beats from the head of the queue.
  mbafr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (head_job),
    .q_valid_i (q_valid),
    .pop_o     (pop),
    .re_o      (ram_re),
    .raddr_o   (ram_raddr),
    .rdata_i   (ram_rdata),
    .res_o     (res_o)
  );

endmodule

/* rtl/mbafr_ram.sv */
// Generic simple dual-port RAM with registered read data.
module mbafr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mbafr_front.sv */
// Character side: frame sync, hex decode, LRC, frame checks and job hand-off.
module mbafr_front import mbafr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  mbafr_char_if.sink        rx_i,
  input  logic              q_full_i,
  output logic              push_o,
  output job_t              job_o,
  output logic              ram_we_o,
  output logic [AddrW:0]    ram_waddr_o,
  output logic [7:0]        ram_wdata_o
);

  function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
    logic [3:0] nib;
    nib = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) nib = ch[3:0];
    else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      nib = 4'(ch[3:0] + 4'd9);
    end
    return nib;
  endfunction

  logic [7:0]       own_addr_q;
  logic             in_frame_q, in_frame_d;
  logic [CharW-1:0] cc_q, cc_d;
  logic [3:0]       hi_q, hi_d;
  logic [7:0]       lrc_q, lrc_d;
  logic             seen_cr_q, seen_cr_d;
  logic             bank_q;
  logic [7:0]       hdr_q [HdrBytes];

  logic             accept;
  logic [7:0]       ch;
  logic [3:0]       nib;
  logic [CharW-1:0] cc_n;
  logic [IdxW-1:0]  idx;
  logic [IdxW-1:0]  ndata_full;
  logic [7:0]       byte_v;
  logic             crlf;
  logic [7:0]       fn;
  logic             fixed_fn;
  logic             fixed_frame;
  logic             store;
  logic             hdr_we;

  assign rx_i.ready = !q_full_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign ch         = rx_i.rx_char;
  assign nib        = hex_nibble(ch);
  assign cc_n       = cc_q + CharW'(1);
  // Byte index of the pair that ends with this character.
  assign idx        = cc_n[CharW-1:1] - IdxW'(1);
  assign byte_v     = {hi_q, nib};
  assign crlf       = seen_cr_q && (ch == ChLf);
  assign fn         = hdr_q[1];
  assign fixed_fn   = (fn == FnReadCoils) || (fn == FnReadRegs) || (fn == FnWriteCoil);
  assign ndata_full = idx - IdxW'(FirstDataByte + 1);

  always_comb begin
    in_frame_d  = in_frame_q;
    cc_d        = cc_q;
    hi_d        = hi_q;
    lrc_d       = lrc_q;
    seen_cr_d   = seen_cr_q;
    push_o      = 1'b0;
    store       = 1'b0;
    fixed_frame = 1'b0;
    if (accept) begin
      if (ch == ChColon) begin
        in_frame_d = 1'b1;
        cc_d       = CharW'(1);
        hi_d       = 4'd0;
        lrc_d      = 8'd0;
        seen_cr_d  = 1'b0;
      end else if (in_frame_q) begin
        cc_d = cc_n;
        if (!cc_n[0]) begin
          hi_d      = nib;
          seen_cr_d = (ch == ChCr);
        end else if (idx >= IdxW'(2) && fixed_fn && cc_n == CharW'(FixedFrameChars)) begin
          in_frame_d  = 1'b0;
          fixed_frame = 1'b1;
          // Of the fixed-length codes, broadcast is only allowed for the single coil write.
          push_o      = crlf && (lrc_q == 8'd0) && ((fn == FnWriteCoil) || (hdr_q[0] != 8'd0));
        end else if (idx >= IdxW'(2) && fn == FnWriteCoils &&
                     cc_n >= CharW'(MinCoilFrameChars) && crlf) begin
          in_frame_d = 1'b0;
          push_o     = (lrc_q == 8'd0);
        end else if (idx >= IdxW'(MaxFrameBytes)) begin
          in_frame_d = 1'b0;
        end else begin
          store = 1'b1;
          lrc_d = lrc_q + byte_v;
          if (idx == IdxW'(0)) begin
            if (byte_v != 8'd0 && byte_v != own_addr_q) in_frame_d = 1'b0;
          end else if (idx == IdxW'(1)) begin
            if (byte_v != FnReadCoils && byte_v != FnReadRegs &&
                byte_v != FnWriteCoil && byte_v != FnWriteCoils) begin
              in_frame_d = 1'b0;
            end
          end else if (idx == IdxW'(5) && fn == FnWriteCoil && byte_v != 8'd0) begin
            in_frame_d = 1'b0;
          end
        end
      end
    end
  end

  assign hdr_we = store && (idx < IdxW'(HdrBytes));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OwnAddrReset;
      in_frame_q <= 1'b0;
      cc_q       <= '0;
      hi_q       <= 4'd0;
      lrc_q      <= 8'd0;
      seen_cr_q  <= 1'b0;
      bank_q     <= 1'b0;
    end else begin
      if (cfg_we_i) own_addr_q <= cfg_wdata_i;
      in_frame_q <= in_frame_d;
      cc_q       <= cc_d;
      hi_q       <= hi_d;
      lrc_q      <= lrc_d;
      seen_cr_q  <= seen_cr_d;
      if (push_o) bank_q <= !bank_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[idx[HdrIdxW-1:0]] <= byte_v;
    end
  end

  assign ram_we_o    = store;
  assign ram_waddr_o = {bank_q, idx[AddrW-1:0]};
  assign ram_wdata_o = byte_v;

  assign job_o.bank  = bank_q;
  assign job_o.fn    = fn;
  assign job_o.bcast = (hdr_q[0] == 8'd0);
  assign job_o.start = {hdr_q[2], hdr_q[3]};
  assign job_o.count = {hdr_q[4], hdr_q[5]};
  assign job_o.ndata = fixed_frame ? '0 : ndata_full[AddrW-1:0];

endmodule

/* rtl/mbafr_job_queue.sv */
// Small queue of accepted frames between the character and result sides.
`include "modbus_ascii_frame_receiver_core_assert.svh"
module mbafr_job_queue import mbafr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic valid_o,
  output logic full_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(p + PtrW'(1));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o   = entry_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(QueueDepth));

  `MBAFR_ASSERT_NEVER(push_when_full, push_i && full_o)
  `MBAFR_ASSERT_NEVER(pop_when_empty, pop_i && !valid_o)

endmodule

/* rtl/mbafr_back.sv */
// Result side: emits the header and the coil data bytes of each queued frame.
`include "modbus_ascii_frame_receiver_core_assert.svh"
module mbafr_back import mbafr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  job_t           job_i,
  input  logic           q_valid_i,
  output logic           pop_o,
  output logic           re_o,
  output logic [AddrW:0] raddr_o,
  input  logic [7:0]     rdata_i,
  mbafr_result_if.source res_o
);

  back_state_e      state_q, state_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [AddrW-1:0] left_q, left_d;

  logic             out_valid_q;
  logic             out_kind_q;
  logic [7:0]       out_fn_q;
  logic             out_bcast_q;
  logic [15:0]      out_start_q;
  logic [15:0]      out_count_q;
  logic [7:0]       out_data_q;
  logic             out_last_q;

  logic out_free;
  logic load_hdr;
  logic load_dat;

  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    left_d   = left_q;
    pop_o    = 1'b0;
    re_o     = 1'b0;
    load_hdr = 1'b0;
    load_dat = 1'b0;
    case (state_q)
      BackIdle: begin
        if (q_valid_i && out_free) begin
          load_hdr = 1'b1;
          if (job_i.ndata == '0) begin
            pop_o = 1'b1;
          end else begin
            rd_idx_d = AddrW'(FirstDataByte);
            left_d   = job_i.ndata;
            state_d  = BackRead;
          end
        end
      end
      BackRead: begin
        re_o    = 1'b1;
        state_d = BackLoad;
      end
      BackLoad: begin
        if (out_free) begin
          load_dat = 1'b1;
          if (left_q == AddrW'(1)) begin
            pop_o   = 1'b1;
            state_d = BackIdle;
          end else begin
            rd_idx_d = rd_idx_q + AddrW'(1);
            left_d   = left_q - AddrW'(1);
            state_d  = BackRead;
          end
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase
  end

  assign raddr_o = {job_i.bank, rd_idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_hdr || load_dat) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    left_q   <= left_d;
    if (load_hdr || load_dat) begin
      out_kind_q  <= load_dat ? KindData : KindHeader;
      out_fn_q    <= job_i.fn;
      out_bcast_q <= job_i.bcast;
      out_start_q <= job_i.start;
      out_count_q <= job_i.count;
      out_data_q  <= load_dat ? rdata_i : 8'd0;
      out_last_q  <= load_dat ? (left_q == AddrW'(1)) : (job_i.ndata == '0);
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.item_kind      = out_kind_q;
  assign res_o.function_code  = out_fn_q;
  assign res_o.is_broadcast   = out_bcast_q;
  assign res_o.start_address  = out_start_q;
  assign res_o.count_or_value = out_count_q;
  assign res_o.data_byte      = out_data_q;
  assign res_o.last_of_frame  = out_last_q;

  `MBAFR_ASSERT(busy_has_job, (state_q != BackIdle) |-> q_valid_i)
  `MBAFR_ASSERT(data_only_fn15, (out_valid_q && out_kind_q == KindData) |-> (out_fn_q == FnWriteCoils))
  `MBAFR_ASSERT(lone_hdr_not_fn15, (out_valid_q && out_kind_q == KindHeader && out_last_q) |-> (out_fn_q != FnWriteCoils))

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus ASCII frame receiver core.
module tb_top;
  import mbafr_pkg::*;

  // Drain and timing limits, in clock cycles.
  localparam int unsigned DrainSettle = 150;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned LongHold    = 400;
  // Least number of counted characters sent in each random phase.
  localparam int unsigned PhaseChars  = 40;

  // One beat on the result channel, field for field.
  typedef struct packed {
    logic        kind;
    logic [7:0]  fn;
    logic        bcast;
    logic [15:0] start;
    logic [15:0] count;
    logic [7:0]  data;
    logic        last;
  } frame_beat_t;

  // Ways in which a generated frame can be damaged on purpose.
  typedef enum int {
    FlawNone,
    FlawLrc,
    FlawCrLf,
    FlawNonHex,
    FlawCut,
    FlawExtraCrLf
  } flaw_e;

  // Tracks the character stream as the core should parse it and keeps the
  // beats that the core still owes, oldest first.
  class frame_tracker;
    logic [7:0]  station;
    bit          in_frame;
    int unsigned chars;
    logic [3:0]  high_nib;
    logic [7:0]  bytes [MaxFrameBytes];
    logic [7:0]  lrc;
    bit          cr_seen;
    frame_beat_t pending_beats [$];
    int unsigned beats_expected;
    int unsigned errors;

    function new();
      station = OwnAddrReset;
      in_frame = 1'b0;
      chars = 0;
      high_nib = '0;
      lrc = '0;
      cr_seen = 1'b0;
      beats_expected = 0;
      errors = 0;
      foreach (bytes[i]) bytes[i] = '0;
    endfunction

    function logic [3:0] nibble_of(logic [7:0] ch);
      if (ch >= 8'h30 && ch <= 8'h39) return ch[3:0];
      if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) return ch[3:0] + 4'd9;
      return 4'd0;
    endfunction

    function bit known_fn(logic [7:0] fn);
      return fn == FnReadCoils || fn == FnReadRegs || fn == FnWriteCoil || fn == FnWriteCoils;
    endfunction

    function void push_beat(logic kind, logic [7:0] data, logic last);
      frame_beat_t b;
      b.kind  = kind;
      b.fn    = bytes[1];
      b.bcast = (bytes[0] == 8'h00);
      b.start = {bytes[2], bytes[3]};
      b.count = {bytes[4], bytes[5]};
      b.data  = data;
      b.last  = last;
      pending_beats.push_back(b);
      beats_expected++;
    endfunction

    // Takes one accepted character. Returns 1 unless the character was
    // ignored because no frame was open.
    function bit note_char(logic [7:0] ch);
      int unsigned idx;
      int unsigned i;
      logic [7:0]  fn;
      logic [7:0]  b;
      bit          crlf;
      if (ch == ChColon) begin
        in_frame = 1'b1;
        chars = 1;
        high_nib = '0;
        lrc = '0;
        cr_seen = 1'b0;
        return 1'b1;
      end
      if (!in_frame) return 1'b0;
      chars++;
      if (chars % 2 == 0) begin
        high_nib = nibble_of(ch);
        cr_seen = (ch == ChCr);
        return 1'b1;
      end
      idx = (chars - 3) / 2;
      crlf = cr_seen && ch == ChLf;
      fn = bytes[1];
      if (idx >= 2 && (fn == FnReadCoils || fn == FnReadRegs || fn == FnWriteCoil) &&
          chars == FixedFrameChars) begin
        in_frame = 1'b0;
        // Reads sent as broadcast are dropped along with bad trailers and LRCs.
        if (crlf && lrc == 8'h00 && !(fn != FnWriteCoil && bytes[0] == 8'h00))
          push_beat(KindHeader, 8'h00, 1'b1);
        return 1'b1;
      end
      if (idx >= 2 && fn == FnWriteCoils && chars >= MinCoilFrameChars && crlf) begin
        in_frame = 1'b0;
        if (lrc == 8'h00) begin
          push_beat(KindHeader, 8'h00, 1'b0);
          for (i = FirstDataByte; i + 1 < idx && i < MaxFrameBytes; i++)
            push_beat(KindData, bytes[i], i + 2 == idx);
        end
        return 1'b1;
      end
      if (idx >= MaxFrameBytes) begin
        in_frame = 1'b0;
        return 1'b1;
      end
      b = {high_nib, nibble_of(ch)};
      bytes[idx] = b;
      lrc += b;
      if (idx == 0) begin
        if (b != 8'h00 && b != station) in_frame = 1'b0;
      end else if (idx == 1) begin
        if (!known_fn(b)) in_frame = 1'b0;
      end else if (idx == 5 && fn == FnWriteCoil && b != 8'h00) begin
        in_frame = 1'b0;
      end
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(frame_beat_t got);
      frame_beat_t want;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got %p", $time, got);
        return;
      end
      want = pending_beats.pop_front();
      compare_field("item_kind", 16'(want.kind), 16'(got.kind));
      compare_field("function_code", 16'(want.fn), 16'(got.fn));
      compare_field("is_broadcast", 16'(want.bcast), 16'(got.bcast));
      compare_field("start_address", want.start, got.start);
      compare_field("count_or_value", want.count, got.count);
      compare_field("data_byte", 16'(want.data), 16'(got.data));
      compare_field("last_of_frame", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;

  always #5 clk_i = ~clk_i;

  mbafr_char_if   rx_if ();
  mbafr_result_if res_if ();

  modbus_ascii_frame_receiver_core dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  frame_tracker tracker = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned counted_chars = 0;
  logic [7:0]  tx_chars [$];

  // Result side: check every beat taken at the rising edge, then choose the
  // next ready value at the falling edge. A long hold-off overrides the
  // random stalls so the frame banks fill and the character side backs up.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        tracker.check_beat('{res_if.item_kind, res_if.function_code, res_if.is_broadcast,
                             res_if.start_address, res_if.count_or_value,
                             res_if.data_byte, res_if.last_of_frame});
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  // The valid stays high on return so back-to-back characters have no gap.
  task automatic send_char(input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_char <= ch;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    if (tracker.note_char(ch)) counted_chars++;
    @(negedge clk_i);
  endtask

  task automatic send_queued();
    foreach (tx_chars[i]) send_char(tx_chars[i]);
    tx_chars.delete();
  endtask

  // Stops the character side and waits for all owed beats, then lets the
  // core settle so a dropped frame cannot still be in flight.
  task automatic wait_drain(input int unsigned limit);
    int unsigned n;
    n = 0;
    rx_if.valid <= 1'b0;
    while (tracker.pending_beats.size() != 0 && n < limit) begin
      @(negedge clk_i);
      n++;
    end
    repeat (DrainSettle) @(negedge clk_i);
  endtask

  task automatic write_station(input logic [7:0] addr);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.station = addr;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  // Appends one encoded frame to tx_chars. Function 15 frames carry a byte
  // count and ndata coil bytes; other codes get the fixed 17 character form.
  function automatic void make_frame(input logic [7:0] addr, input logic [7:0] fn,
                                     input logic [15:0] start, input logic [15:0] cv,
                                     input int unsigned ndata, input flaw_e flaw);
    logic [7:0]  body [$];
    logic [7:0]  sum;
    int unsigned pos;
    body = '{addr, fn, start[15:8], start[7:0], cv[15:8], cv[7:0]};
    if (fn == FnWriteCoils) begin
      body.push_back(ndata[7:0]);
      repeat (ndata) body.push_back(8'($urandom_range(255)));
    end
    sum = 8'h00;
    foreach (body[i]) sum += body[i];
    sum = -sum;
    if (flaw == FlawLrc) sum += 8'($urandom_range(255, 1));
    body.push_back(sum);
    pos = tx_chars.size();
    tx_chars.push_back(ChColon);
    foreach (body[i]) begin
      tx_chars.push_back(hex_char(body[i][7:4]));
      tx_chars.push_back(hex_char(body[i][3:0]));
    end
    tx_chars.push_back(ChCr);
    tx_chars.push_back(ChLf);
    case (flaw)
      FlawCrLf: begin
        tx_chars[tx_chars.size() - 1 - $urandom_range(1)] ^= 8'($urandom_range(255, 1));
      end
      FlawNonHex: begin
        tx_chars[pos + $urandom_range(2 * body.size(), 1)] = 8'($urandom_range(255));
      end
      FlawCut: begin
        tx_chars = tx_chars[0 : pos + $urandom_range(2 * body.size())];
      end
      FlawExtraCrLf: begin
        tx_chars.push_back(ChCr);
        tx_chars.push_back(ChLf);
      end
      default: ;
    endcase
  endfunction

  // Mostly well-formed frames for this station with random content, plus
  // broadcasts, foreign stations, odd codes, damaged frames and line noise.
  task automatic random_frame();
    logic [7:0]  addr;
    logic [7:0]  fn;
    logic [15:0] cv;
    int unsigned ndata;
    int unsigned pick;
    flaw_e       flaw;
    pick = $urandom_range(99);
    addr = (pick < 60) ? tracker.station : (pick < 75) ? 8'h00 : 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 22) fn = FnReadCoils;
    else if (pick < 44) fn = FnReadRegs;
    else if (pick < 66) fn = FnWriteCoil;
    else if (pick < 90) fn = FnWriteCoils;
    else fn = 8'($urandom_range(255));
    cv = 16'($urandom_range(65535));
    if (fn == FnWriteCoil && $urandom_range(9) < 8) cv[7:0] = 8'h00;
    // Long coil frames are slow to drain, so only a few are used.
    ndata = ($urandom_range(19) == 0) ? $urandom_range(57, 40) : $urandom_range(8, 1);
    pick = $urandom_range(99);
    flaw = (pick < 70) ? FlawNone : flaw_e'(1 + pick % 5);
    repeat ($urandom_range(3)) tx_chars.push_back(8'($urandom_range(255)));
    make_frame(addr, fn, 16'($urandom_range(65535)), cv, ndata, flaw);
    send_queued();
  endtask

  initial begin
    int          phase;
    int unsigned target;
    rx_if.valid   = 1'b0;
    rx_if.rx_char = 8'h00;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames at the reset station address of 1.
    make_frame(8'h01, FnReadCoils, 16'h0000, 16'h0000, 0, FlawNone);
    make_frame(8'h01, FnReadRegs, 16'hFFFF, 16'hFFFF, 0, FlawNone);
    make_frame(8'h01, FnWriteCoil, 16'h1234, 16'hFF00, 0, FlawNone);
    make_frame(8'h00, FnWriteCoil, 16'h0000, 16'h0000, 0, FlawNone);
    make_frame(8'h01, FnWriteCoils, 16'h0013, 16'h0008, 1, FlawNone);
    make_frame(8'h00, FnWriteCoils, 16'hFFFF, 16'hFFFF, 3, FlawNone);
    // The largest frame that fits the store, then one byte more.
    make_frame(8'h01, FnWriteCoils, 16'h0000, 16'h01C0, 56, FlawNone);
    make_frame(8'h01, FnWriteCoils, 16'h0000, 16'h01C8, 57, FlawNone);
    // Foreign stations and unknown function codes.
    make_frame(8'h02, FnReadCoils, 16'h0001, 16'h0002, 0, FlawNone);
    make_frame(8'hFF, FnReadRegs, 16'h0001, 16'h0002, 0, FlawNone);
    make_frame(8'h01, 8'h10, 16'h0001, 16'h0002, 0, FlawNone);
    make_frame(8'h01, 8'h00, 16'h0001, 16'h0002, 0, FlawNone);
    make_frame(8'h01, 8'hFF, 16'h0001, 16'h0002, 0, FlawNone);
    // A single coil write with a nonzero low value byte.
    make_frame(8'h01, FnWriteCoil, 16'h0001, 16'hFF01, 0, FlawNone);
    make_frame(8'h01, FnReadRegs, 16'h0100, 16'h0004, 0, FlawLrc);
    make_frame(8'h01, FnReadCoils, 16'h0100, 16'h0004, 0, FlawCrLf);
    // Reads sent as broadcast.
    make_frame(8'h00, FnReadCoils, 16'h0000, 16'h0001, 0, FlawNone);
    make_frame(8'h00, FnReadRegs, 16'h0000, 16'h0001, 0, FlawNone);
    // Coil frame whose first CR LF comes too early and is taken as a byte.
    make_frame(8'h01, FnWriteCoils, 16'h0020, 16'h0000, 0, FlawExtraCrLf);
    // A frame cut short by the next colon, and one with a non-hex digit.
    make_frame(8'h01, FnReadRegs, 16'h0AAA, 16'h0055, 0, FlawCut);
    make_frame(8'h01, FnReadRegs, 16'h0AAA, 16'h0055, 0, FlawNonHex);
    tx_chars.push_back(8'hFF);
    tx_chars.push_back(8'h80);
    tx_chars.push_back(8'h00);
    tx_chars.push_back(8'h7F);
    make_frame(8'h01, FnWriteCoil, 16'hFFFF, 16'h0000, 0, FlawNone);
    // Hold the result side off while the directed frames stream in, so the
    // frame banks fill and the character side stalls.
    hold_left = LongHold;
    send_queued();
    wait_drain(DrainLimit);

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_station(8'hFF);
          // Hold the result side off while frames keep coming.
          hold_left = LongHold;
        end
        1: begin
          send_idle_pct = 52;
          recv_stall_pct = 0;
          write_station(8'($urandom_range(254, 2)));
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 52;
          write_station(8'h01);
        end
        default: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
          write_station(8'($urandom_range(255, 1)));
        end
      endcase
      target = counted_chars + PhaseChars;
      while (counted_chars < target) random_frame();
      // The sender pauses here until every owed beat has been taken.
      wait_drain(DrainLimit);
    end

    if (tracker.pending_beats.size() != 0) begin
      tracker.errors += tracker.pending_beats.size();
      $display("%0t: %0d expected result beats never arrived", $time,
               tracker.pending_beats.size());
    end
    if (tracker.errors == 0) begin
      $display("** modbus_ascii_frame_receiver_core: PASSED **");
    end else begin
      $display("** modbus_ascii_frame_receiver_core: FAILED **");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("** modbus_ascii_frame_receiver_core: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/mbafr_pkg.sv
rtl/mbafr_char_if.sv
rtl/mbafr_result_if.sv
rtl/mbafr_ram.sv
rtl/mbafr_front.sv
rtl/mbafr_job_queue.sv
rtl/mbafr_back.sv
rtl/modbus_ascii_frame_receiver_core.sv
dv/tb_top.sv
